// File: rtl/hufrle_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the squeeze Huffman decoder with RLE90 expansion.
// No dependencies.
package hufrle_pkg;

	localparam int MAX_SYMBOLS = 257;
	localparam logic [15:0] EMPTY_LEAF = 16'hFEFF;
	localparam logic [7:0] RLE_MARK = 8'h90;

	typedef enum logic [1:0] {
		PH_COUNT,
		PH_LOAD,
		PH_DECODE,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_BIT,
		SQ_FLUSH
	} seq_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_COUNT = 2'd1,
		ERR_CHILD = 2'd2
	} err_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] repeat_count;
		logic       end_of_stream;
		err_t       error_code;
	} rec_t;

endpackage

// File: rtl/huffman_unsqueeze_rle90.sv
`timescale 1ns / 1ps
// Squeeze Huffman decoder with RLE90 run expansion, one compressed byte per beat.
// Depends on hufrle_pkg and hufrle_ram (node table).
// Count and table bytes are taken in the idle state; a count byte that raises the error
// moves on to the flush state to hand its record over. A decode byte is accepted in the
// idle state, walks one tree bit per step in the bit state (at most 8, one node table
// read each) and ends in the flush state; the output side can stall a record.
// Reset clears all control state; the node table is not cleared, entries at or
// beyond twice the node count read as their cleared value.
module huffman_unsqueeze_rle90
	import hufrle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic [0:0]  s_tuser,   // [0] stream_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] repeat_count
	output logic [2:0]  m_tuser,   // [0] end_of_stream, [2:1] error_code
	output logic        m_tlast
);

	seq_t        state_q, state_n;
	phase_t      phase_q, phase_n;
	logic [8:0]  node_count_q, node_count_n;
	logic [9:0]  load_q, load_n;
	logic [7:0]  low_q, low_n;
	logic [8:0]  pos_q, pos_n;
	logic [7:0]  rle_last_q, rle_last_n;
	logic        rle_mark_q, rle_mark_n;
	logic [7:0]  byte_q, byte_n;
	logic [2:0]  bit_q, bit_n;
	logic [9:0]  idx_q, idx_n;
	rec_t        pend_q, pend_n;
	logic        pend_valid_q, pend_valid_n;
	rec_t        out_q, out_n;
	logic        out_valid_q, out_valid_n;
	logic        out_last_q, out_last_n;

	logic        ram_we;
	logic [8:0]  ram_wr_addr;
	logic [15:0] ram_wr_data;
	logic [8:0]  ram_rd_addr;
	logic [15:0] ram_rd_data;

	logic [15:0] word;
	logic        out_free;
	logic        accept;
	logic [15:0] cnt_word;
	logic [9:0]  load_nx;
	logic [2:0]  bit_nx;
	logic        rec_gen;
	rec_t        rec;
	logic [7:0]  sym_low;
	logic        stall;

	hufrle_ram #(
		.WIDTH(16),
		.DEPTH(512)
	) u_table (
		.clk    (clk),
		.we     (ram_we),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// Entries past the loaded table read as cleared: root pair holds the end leaf.
	always_comb begin
		if (idx_q < {node_count_q, 1'b0}) begin
			word = ram_rd_data;
		end else if (idx_q[9:1] == 9'd0) begin
			word = EMPTY_LEAF;
		end else begin
			word = 16'd0;
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign cnt_word = {s_tdata, low_q};
	assign load_nx  = load_q + 10'd1;
	assign bit_nx   = bit_q + 3'd1;
	assign sym_low  = ~word[7:0];

	always_comb begin
		state_n      = state_q;
		phase_n      = phase_q;
		node_count_n = node_count_q;
		load_n       = load_q;
		low_n        = low_q;
		pos_n        = pos_q;
		rle_last_n   = rle_last_q;
		rle_mark_n   = rle_mark_q;
		byte_n       = byte_q;
		bit_n        = bit_q;
		idx_n        = idx_q;
		pend_n       = pend_q;
		pend_valid_n = pend_valid_q;
		out_n        = out_q;
		out_valid_n  = out_valid_q && !m_tready;
		out_last_n   = out_last_q;
		ram_we       = 1'b0;
		ram_wr_addr  = load_q[9:1];
		ram_wr_data  = {s_tdata, low_q};
		ram_rd_addr  = {pos_q[7:0], s_tdata[0]};
		rec_gen      = 1'b0;
		rec          = '{out_byte: 8'd0, repeat_count: 8'd0, end_of_stream: 1'b0,
			error_code: ERR_NONE};
		stall        = 1'b0;
		s_tready     = 1'b0;

		unique case (state_q)
			SQ_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					if (s_tuser[0]) begin
						// New stream: restart the count word and clear run state.
						node_count_n = 9'd0;
						pos_n        = 9'd0;
						rle_last_n   = 8'd0;
						rle_mark_n   = 1'b0;
						low_n        = s_tdata;
						load_n       = 10'd1;
						phase_n      = PH_COUNT;
					end else begin
						unique case (phase_q)
							PH_COUNT: begin
								if (!load_q[0]) begin
									low_n  = s_tdata;
									load_n = 10'd1;
								end else begin
									load_n = 10'd0;
									if (cnt_word >= 16'(MAX_SYMBOLS)) begin
										phase_n      = PH_DONE;
										pend_n       = '{out_byte: 8'd0, repeat_count: 8'd0,
											end_of_stream: 1'b0, error_code: ERR_COUNT};
										pend_valid_n = 1'b1;
										state_n      = SQ_FLUSH;
									end else begin
										node_count_n = cnt_word[8:0];
										pos_n        = 9'd0;
										phase_n      = (cnt_word == 16'd0) ? PH_DECODE : PH_LOAD;
									end
								end
							end
							PH_LOAD: begin
								if (!load_q[0]) begin
									low_n = s_tdata;
								end else begin
									ram_we = 1'b1;
								end
								load_n = load_nx;
								if (({1'b0, load_nx} == {node_count_q, 2'b00}) ||
									(load_nx == 10'd0)) begin
									load_n  = 10'd0;
									pos_n   = 9'd0;
									phase_n = PH_DECODE;
								end
							end
							PH_DECODE: begin
								byte_n      = s_tdata;
								bit_n       = 3'd0;
								idx_n       = {pos_q, s_tdata[0]};
								ram_rd_addr = idx_n[8:0];
								state_n     = SQ_BIT;
							end
							PH_DONE: begin
							end
							default: begin
							end
						endcase
					end
				end
			end
			SQ_BIT: begin
				if (!word[15]) begin
					if (word >= 16'(MAX_SYMBOLS)) begin
						rec_gen         = 1'b1;
						rec.error_code  = ERR_CHILD;
						phase_n         = PH_DONE;
					end else begin
						pos_n = word[8:0];
					end
				end else begin
					pos_n = 9'd0;
					if (word == EMPTY_LEAF) begin
						rec_gen           = 1'b1;
						rec.end_of_stream = 1'b1;
						phase_n           = PH_DONE;
					end else if (rle_mark_q) begin
						rle_mark_n = 1'b0;
						if (sym_low == 8'd0) begin
							rle_last_n       = RLE_MARK;
							rec_gen          = 1'b1;
							rec.out_byte     = RLE_MARK;
							rec.repeat_count = 8'd1;
						end else if (sym_low != 8'd1) begin
							rec_gen          = 1'b1;
							rec.out_byte     = rle_last_q;
							rec.repeat_count = sym_low - 8'd1;
						end
					end else if (sym_low == RLE_MARK) begin
						rle_mark_n = 1'b1;
					end else begin
						rle_last_n       = sym_low;
						rec_gen          = 1'b1;
						rec.out_byte     = sym_low;
						rec.repeat_count = 8'd1;
					end
				end

				stall = rec_gen && pend_valid_q && !out_free;
				if (stall) begin
					// Hold: reread the same entry and keep all state.
					phase_n     = phase_q;
					pos_n       = pos_q;
					rle_last_n  = rle_last_q;
					rle_mark_n  = rle_mark_q;
					ram_rd_addr = idx_q[8:0];
				end else begin
					if (rec_gen) begin
						if (pend_valid_q) begin
							out_n       = pend_q;
							out_valid_n = 1'b1;
							out_last_n  = 1'b0;
						end
						pend_n       = rec;
						pend_valid_n = 1'b1;
					end
					if ((phase_n != PH_DECODE) || (bit_q == 3'd7)) begin
						state_n = SQ_FLUSH;
					end else begin
						bit_n       = bit_nx;
						idx_n       = {pos_n, byte_q[bit_nx]};
						ram_rd_addr = idx_n[8:0];
					end
				end
			end
			SQ_FLUSH: begin
				if (pend_valid_q) begin
					if (out_free) begin
						out_n        = pend_q;
						out_valid_n  = 1'b1;
						out_last_n   = 1'b1;
						pend_valid_n = 1'b0;
						state_n      = SQ_IDLE;
					end
				end else begin
					state_n = SQ_IDLE;
				end
			end
			default: begin
				state_n = SQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SQ_IDLE;
			phase_q      <= PH_COUNT;
			node_count_q <= 9'd0;
			load_q       <= 10'd0;
			low_q        <= 8'd0;
			pos_q        <= 9'd0;
			rle_last_q   <= 8'd0;
			rle_mark_q   <= 1'b0;
			bit_q        <= 3'd0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			state_q      <= state_n;
			phase_q      <= phase_n;
			node_count_q <= node_count_n;
			load_q       <= load_n;
			low_q        <= low_n;
			pos_q        <= pos_n;
			rle_last_q   <= rle_last_n;
			rle_mark_q   <= rle_mark_n;
			bit_q        <= bit_n;
			pend_valid_q <= pend_valid_n;
			out_valid_q  <= out_valid_n;
			out_last_q   <= out_last_n;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_n;
		idx_q  <= idx_n;
		pend_q <= pend_n;
		out_q  <= out_n;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.repeat_count, out_q.out_byte};
	assign m_tuser  = {out_q.error_code, out_q.end_of_stream};
	assign m_tlast  = out_last_q;

	a_bit_in_decode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SQ_BIT |-> phase_q == PH_DECODE)
		else $error("tree walk outside decode phase");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SQ_IDLE |-> !pend_valid_q)
		else $error("record left pending across input beats");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < 9'(MAX_SYMBOLS))
		else $error("tree position beyond table");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		node_count_q < 9'(MAX_SYMBOLS))
		else $error("node count beyond limit");

	a_error_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2:1] != ERR_NONE) |-> m_tlast)
		else $error("error record not final");

endmodule

// File: rtl/hufrle_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hufrle_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
